// ===== sv/vccr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vccr_pkg;

    // quotient bits resolved by the divider, one per stage
    localparam int unsigned DIV_STEPS = 31;
    localparam int unsigned DIV_LAT   = DIV_STEPS + 1;

    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [31:0] Q30_GAIN    = 32'sd652032874;
    localparam logic signed [33:0] Q16_PI      = 34'sd205887;
    localparam logic signed [33:0] Q16_TWO_PI  = 34'sd411775;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    typedef enum logic [2:0] {
        CFG_MIN_FWD  = 3'd0,
        CFG_MAX_FWD  = 3'd1,
        CFG_MAX_LAT  = 3'd2,
        CFG_MAX_TURN = 3'd3,
        CFG_DT       = 3'd4
    } t_cfg_idx;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/vccr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface vccr_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sum_vx;
    logic signed [31:0] sum_vy;
    logic signed [31:0] sum_omega;
    logic signed [31:0] weight_sum;
    logic signed [18:0] current_heading;
    logic               global_frame;

    modport source (output valid, sum_vx, sum_vy, sum_omega, weight_sum,
                    current_heading, global_frame, input ready);
    modport sink (input valid, sum_vx, sum_vy, sum_omega, weight_sum,
                  current_heading, global_frame, output ready);
endinterface

interface vccr_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_vx;
    logic signed [31:0] out_vy;
    logic signed [31:0] out_turn;
    logic signed [31:0] body_vx;
    logic signed [31:0] body_vy;
    logic signed [31:0] body_omega;
    logic               frame_echo;

    modport source (output valid, out_vx, out_vy, out_turn, body_vx, body_vy,
                    body_omega, frame_echo, input ready);
    modport sink (input valid, out_vx, out_vy, out_turn, body_vx, body_vy,
                  body_omega, frame_echo, output ready);
endinterface

interface vccr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/velocity_command_clamp_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// velocity command clamp and frame rotation
// i_cmd carries one word: three weighted velocity sums, the weight sum, the
// current heading and the frame bit. o_res returns exactly one word per
// command: the output velocities and turn value plus the clamped body values.
// i_cfg writes the clamp limits and time step by index; it is always ready,
// and the user must write it only while no command is in flight; the block
// itself does not enforce this. The stages from acceptance to o_res.valid are
// 32 divider stages, one clamp stage, CORDIC_ITERATIONS + 1 CORDIC stages, a
// product stage, a sum stage and the output register. A new word is accepted
// every cycle while the pipeline is not held.
// the whole pipeline advances together; when o_res.ready is low with a word
// waiting, every stage holds and i_cmd.ready drops, so nothing is lost.
// reset restores the register defaults and clears every valid bit.
module velocity_command_clamp_rotate #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    vccr_cmd_if.sink     i_cmd,
    vccr_res_if.source   o_res,
    vccr_cfg_if.sink     i_cfg
);
    localparam int unsigned DLAT   = vccr_pkg::DIV_LAT;
    localparam int          SIDE_W = 3 * 32 + 19 + 1;

    logic signed [31:0] r_min_fwd;
    logic signed [31:0] r_max_fwd;
    logic [30:0]        r_max_lat;
    logic [30:0]        r_max_turn;
    logic [16:0]        r_dt;

    logic en;

    assign en          = !o_res.valid || o_res.ready;
    assign i_cmd.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fwd  <= 32'sd0;
            r_max_fwd  <= 32'sd65536;
            r_max_lat  <= 31'd32768;
            r_max_turn <= 31'd65536;
            r_dt       <= 17'd3277;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                vccr_pkg::CFG_MIN_FWD:  r_min_fwd  <= i_cfg.data;
                vccr_pkg::CFG_MAX_FWD:  r_max_fwd  <= i_cfg.data;
                vccr_pkg::CFG_MAX_LAT:  r_max_lat  <= i_cfg.data[30:0];
                vccr_pkg::CFG_MAX_TURN: r_max_turn <= i_cfg.data[30:0];
                vccr_pkg::CFG_DT:       r_dt       <= i_cfg.data[16:0];
                default: ;
            endcase
        end
    end

    // division stages, with yaw and frame bit riding alongside
    logic signed [31:0] q_vx, q_vy, q_om;
    logic [DLAT-1:0]    r_dv;
    logic signed [18:0] r_dyaw  [0:DLAT-1];
    logic               r_dglob [0:DLAT-1];

    vccr_div u_div_vx (.i_clk(i_clk), .i_en(en), .i_num(i_cmd.sum_vx),
                       .i_den(i_cmd.weight_sum), .o_quo(q_vx));
    vccr_div u_div_vy (.i_clk(i_clk), .i_en(en), .i_num(i_cmd.sum_vy),
                       .i_den(i_cmd.weight_sum), .o_quo(q_vy));
    vccr_div u_div_om (.i_clk(i_clk), .i_en(en), .i_num(i_cmd.sum_omega),
                       .i_den(i_cmd.weight_sum), .o_quo(q_om));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (en) begin
            r_dv <= {r_dv[DLAT-2:0], i_cmd.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dyaw[0]  <= i_cmd.current_heading;
            r_dglob[0] <= i_cmd.global_frame;
            for (int k = 1; k < DLAT; k++) begin
                r_dyaw[k]  <= r_dyaw[k-1];
                r_dglob[k] <= r_dglob[k-1];
            end
        end
    end

    // clamp stage, upper forward limit wins when the limits cross
    logic signed [31:0] lat_s, turn_s;
    logic signed [31:0] n_vx, n_vy, n_om;
    logic               r_cv;
    logic signed [31:0] r_cvx, r_cvy, r_com;
    logic signed [18:0] r_cyaw;
    logic               r_cglob;

    always_comb begin
        lat_s  = $signed({1'b0, r_max_lat});
        turn_s = $signed({1'b0, r_max_turn});
        n_vx   = (q_vx < r_min_fwd) ? r_min_fwd : q_vx;
        n_vx   = (n_vx > r_max_fwd) ? r_max_fwd : n_vx;
        n_vy   = (q_vy < -lat_s) ? -lat_s : q_vy;
        n_vy   = (n_vy > lat_s) ? lat_s : n_vy;
        n_om   = (q_om < -turn_s) ? -turn_s : q_om;
        n_om   = (n_om > turn_s) ? turn_s : n_om;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (en) begin
            r_cv <= r_dv[DLAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cvx   <= n_vx;
            r_cvy   <= n_vy;
            r_com   <= n_om;
            r_cyaw  <= r_dyaw[DLAT-1];
            r_cglob <= r_dglob[DLAT-1];
        end
    end

    // sine and cosine of the heading
    logic               k_v;
    logic signed [31:0] k_cos, k_sin;
    logic [SIDE_W-1:0]  k_side;
    logic signed [31:0] k_vx, k_vy, k_om;
    logic signed [18:0] k_yaw;
    logic               k_glob;

    vccr_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_W(SIDE_W)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_cv),
        .i_angle (r_cyaw),
        .i_side  ({r_cvx, r_cvy, r_com, r_cyaw, r_cglob}),
        .o_valid (k_v),
        .o_cos   (k_cos),
        .o_sin   (k_sin),
        .o_side  (k_side)
    );

    assign {k_vx, k_vy, k_om, k_yaw, k_glob} = k_side;

    // product stage
    logic               r_pv;
    logic signed [63:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [49:0] r_pod;
    logic signed [31:0] r_pvx, r_pvy, r_pom;
    logic signed [18:0] r_pyaw;
    logic               r_pglob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxc   <= k_vx * k_cos;
            r_pys   <= k_vy * k_sin;
            r_pxs   <= k_vx * k_sin;
            r_pyc   <= k_vy * k_cos;
            r_pod   <= k_om * $signed({1'b0, r_dt});
            r_pvx   <= k_vx;
            r_pvy   <= k_vy;
            r_pom   <= k_om;
            r_pyaw  <= k_yaw;
            r_pglob <= k_glob;
        end
    end

    // sum stage, rounding offsets folded in
    logic               r_sv;
    logic signed [65:0] r_sx, r_sy;
    logic signed [33:0] r_sd;
    logic signed [31:0] r_svx, r_svy, r_som;
    logic               r_sglob;
    logic signed [49:0] pod_rnd;

    always_comb begin
        pod_rnd = r_pod + 50'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (en) begin
            r_sv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx    <= 66'(r_pxc) - 66'(r_pys) + 66'sd536870912;
            r_sy    <= 66'(r_pxs) + 66'(r_pyc) + 66'sd536870912;
            r_sd    <= 34'(r_pyaw) + 34'(pod_rnd >>> 16);
            r_svx   <= r_pvx;
            r_svy   <= r_pvy;
            r_som   <= r_pom;
            r_sglob <= r_pglob;
        end
    end

    // output register: shift, single 2pi wrap, saturate, select
    logic signed [33:0] d_wrap;
    logic signed [31:0] n_ovx, n_ovy, n_oturn;

    always_comb begin
        priority if (r_sd > vccr_pkg::Q16_PI) begin
            d_wrap = r_sd - vccr_pkg::Q16_TWO_PI;
        end else if (r_sd < -vccr_pkg::Q16_PI) begin
            d_wrap = r_sd + vccr_pkg::Q16_TWO_PI;
        end else begin
            d_wrap = r_sd;
        end
        if (r_sglob) begin
            n_ovx   = vccr_pkg::sat32(r_sx >>> 30);
            n_ovy   = vccr_pkg::sat32(r_sy >>> 30);
            n_oturn = vccr_pkg::sat32(66'(d_wrap));
        end else begin
            n_ovx   = r_svx;
            n_ovy   = r_svy;
            n_oturn = r_som;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else if (en) begin
            o_res.valid <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.out_vx     <= n_ovx;
            o_res.out_vy     <= n_ovy;
            o_res.out_turn   <= n_oturn;
            o_res.body_vx    <= r_svx;
            o_res.body_vy    <= r_svy;
            o_res.body_omega <= r_som;
            o_res.frame_echo <= r_sglob;
        end
    end
endmodule
`default_nettype wire

// ===== sv/vccr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vccr_div (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic signed [31:0]      o_quo
);
    localparam int unsigned STAGES = vccr_pkg::DIV_STEPS;

    logic [47:0] r_rem  [0:STAGES];
    logic [30:0] r_quo  [0:STAGES];
    logic [30:0] r_den  [0:STAGES];
    logic        r_neg  [0:STAGES];
    logic        r_sat  [0:STAGES];
    logic        r_zero [0:STAGES];

    logic [31:0] num_mag;
    logic [47:0] num_sh;
    logic        den_pos;

    always_comb begin
        num_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);
        num_sh  = {num_mag, 16'b0};
        den_pos = !i_den[31] && (i_den != 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= num_sh;
            r_quo[0]  <= '0;
            r_den[0]  <= i_den[30:0];
            r_neg[0]  <= i_num[31];
            r_zero[0] <= !den_pos;
            // quotient of 2^31 or more saturates
            r_sat[0]  <= {14'b0, num_sh[47:31]} >= i_den[30:0];
        end
    end

    for (genvar k = 1; k <= STAGES; k++) begin : g_step
        localparam int unsigned B = STAGES - k;
        logic [61:0] w_dsh;
        logic [47:0] w_sub;
        logic        w_take;

        always_comb begin
            w_dsh  = {31'b0, r_den[k-1]} << B;
            w_take = (r_rem[k-1] >> B) >= {17'b0, r_den[k-1]};
            w_sub  = r_rem[k-1] - w_dsh[47:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_take ? w_sub : r_rem[k-1];
                r_quo[k]  <= r_quo[k-1] | (31'(w_take) << B);
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_sat[k]  <= r_sat[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    always_comb begin
        priority if (r_zero[STAGES]) begin
            o_quo = '0;
        end else if (r_sat[STAGES]) begin
            o_quo = r_neg[STAGES] ? 32'sh80000000 : 32'sh7fffffff;
        end else if (r_neg[STAGES]) begin
            o_quo = -$signed({1'b0, r_quo[STAGES]});
        end else begin
            o_quo = $signed({1'b0, r_quo[STAGES]});
        end
    end
endmodule
`default_nettype wire

// ===== sv/vccr_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vccr_cordic #(
    parameter int ITER   = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [18:0] i_angle,
    input  wire logic [SIDE_W-1:0]  i_side,
    output logic                    o_valid,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin,
    output logic [SIDE_W-1:0]       o_side
);
    logic signed [31:0] r_x    [0:ITER];
    logic signed [31:0] r_y    [0:ITER];
    logic signed [33:0] r_z    [0:ITER];
    logic               r_flip [0:ITER];
    logic [SIDE_W-1:0]  r_side [0:ITER];
    logic [ITER:0]      r_vld;

    logic signed [33:0] z0;

    always_comb begin
        z0 = 34'($signed({i_angle, 14'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ITER-1:0], i_valid};
        end
    end

    // fold into +-pi/2, undone by negating the result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= vccr_pkg::Q30_GAIN;
            r_y[0]    <= '0;
            r_side[0] <= i_side;
            if (z0 > vccr_pkg::Q30_HALF_PI) begin
                r_z[0]    <= z0 - vccr_pkg::Q30_PI;
                r_flip[0] <= 1'b1;
            end else if (z0 < -vccr_pkg::Q30_HALF_PI) begin
                r_z[0]    <= z0 + vccr_pkg::Q30_PI;
                r_flip[0] <= 1'b1;
            end else begin
                r_z[0]    <= z0;
                r_flip[0] <= 1'b0;
            end
        end
    end

    for (genvar k = 1; k <= ITER; k++) begin : g_iter
        logic signed [31:0] w_xs;
        logic signed [31:0] w_ys;
        logic signed [33:0] w_at;

        always_comb begin
            w_xs = r_x[k-1] >>> (k - 1);
            w_ys = r_y[k-1] >>> (k - 1);
            w_at = $signed({2'b0, vccr_pkg::ATAN_Q30[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[k] <= r_flip[k-1];
                r_side[k] <= r_side[k-1];
                if (!r_z[k-1][33]) begin
                    r_x[k] <= r_x[k-1] - w_ys;
                    r_y[k] <= r_y[k-1] + w_xs;
                    r_z[k] <= r_z[k-1] - w_at;
                end else begin
                    r_x[k] <= r_x[k-1] + w_ys;
                    r_y[k] <= r_y[k-1] - w_xs;
                    r_z[k] <= r_z[k-1] + w_at;
                end
            end
        end
    end

    always_comb begin
        o_valid = r_vld[ITER];
        o_side  = r_side[ITER];
        o_cos   = r_flip[ITER] ? -r_x[ITER] : r_x[ITER];
        o_sin   = r_flip[ITER] ? -r_y[ITER] : r_y[ITER];
    end
endmodule
`default_nettype wire

// ===== verif/tb_velocity_command_clamp_rotate.sv =====
`timescale 1ns / 1ps
module tb_velocity_command_clamp_rotate;

    localparam int ITERS = 16;
    localparam int LATENCY = ITERS + 36;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] sum_vx;
        logic signed [31:0] sum_vy;
        logic signed [31:0] sum_omega;
        logic signed [31:0] weight_sum;
        logic signed [18:0] heading;
        logic               global_frame;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] out_vx;
        logic signed [31:0] out_vy;
        logic signed [31:0] out_turn;
        logic signed [31:0] body_vx;
        logic signed [31:0] body_vy;
        logic signed [31:0] body_omega;
        logic               frame_echo;
    } t_res;

    logic i_clk;
    logic i_rst_n;
    vccr_cmd_if cmd ();
    vccr_res_if res ();
    vccr_cfg_if cfg ();

    velocity_command_clamp_rotate #(.CORDIC_ITERATIONS(ITERS)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd.sink),
        .o_res  (res.source),
        .i_cfg  (cfg.sink)
    );

    // predictor copy of the limits
    longint lim_min_fwd, lim_max_fwd, lim_max_lat, lim_max_turn, lim_dt;
    t_res   expected_words[$];
    int     error_count;
    longint cycle_count;
    int     hold_off_cycles;
    bit     stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic t_res command_result(t_cmd c);
        t_res   r;
        longint vx, vy, om, yaw, z, x, y, xs, ys, d, wsum;
        int     k;
        bit     flip;
        vx = 0; vy = 0; om = 0;
        wsum = longint'(c.weight_sum);
        yaw = longint'(c.heading);
        if (wsum > 0) begin
            vx = sat_word((longint'(c.sum_vx) * 65536) / wsum);
            vy = sat_word((longint'(c.sum_vy) * 65536) / wsum);
            om = sat_word((longint'(c.sum_omega) * 65536) / wsum);
        end
        vx = clip(vx, lim_min_fwd, lim_max_fwd);
        vy = clip(vy, -lim_max_lat, lim_max_lat);
        om = clip(om, -lim_max_turn, lim_max_turn);
        r.body_vx = 32'(vx);
        r.body_vy = 32'(vy);
        r.body_omega = 32'(om);
        r.frame_echo = c.global_frame;
        if (c.global_frame) begin
            z = yaw * 16384;
            x = 652032874;
            y = 0;
            flip = 0;
            if (z > 64'sd1686629713) begin
                z -= 64'sd3373259426; flip = 1;
            end else if (z < -64'sd1686629713) begin
                z += 64'sd3373259426; flip = 1;
            end
            for (k = 0; k < ITERS && k < 32; k++) begin
                xs = shr_floor(x, k);
                ys = shr_floor(y, k);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(vccr_pkg::ATAN_Q30[k]);
                end else begin
                    x += ys; y -= xs; z += longint'(vccr_pkg::ATAN_Q30[k]);
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            r.out_vx = 32'(sat_word(shr_floor(vx * x - vy * y + (64'sd1 << 29), 30)));
            r.out_vy = 32'(sat_word(shr_floor(vx * y + vy * x + (64'sd1 << 29), 30)));
            d = yaw + shr_floor(om * lim_dt + (64'sd1 << 15), 16);
            if (d > 205887) d -= 411775;
            else if (d < -205887) d += 411775;
            r.out_turn = 32'(sat_word(d));
        end else begin
            r.out_vx = 32'(vx);
            r.out_vy = 32'(vy);
            r.out_turn = 32'(om);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // receiver: own stall pattern plus a long hold-off on request
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                res.ready <= 1'b0;
                hold_off_cycles--;
            end else if (stall_enable) begin
                res.ready <= ($urandom_range(0, 3) != 0);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_words.pop_front();
                if (res.out_vx !== want.out_vx)
                    report_mismatch("out_vx", res.out_vx, want.out_vx);
                if (res.out_vy !== want.out_vy)
                    report_mismatch("out_vy", res.out_vy, want.out_vy);
                if (res.out_turn !== want.out_turn)
                    report_mismatch("out_turn", res.out_turn, want.out_turn);
                if (res.body_vx !== want.body_vx)
                    report_mismatch("body_vx", res.body_vx, want.body_vx);
                if (res.body_vy !== want.body_vy)
                    report_mismatch("body_vy", res.body_vy, want.body_vy);
                if (res.body_omega !== want.body_omega)
                    report_mismatch("body_omega", res.body_omega, want.body_omega);
                if (res.frame_echo !== want.frame_echo)
                    report_mismatch("frame_echo", res.frame_echo, want.frame_echo);
            end
        end
    end

    task automatic send_command(t_cmd c);
        cmd.valid           <= 1'b1;
        cmd.sum_vx          <= c.sum_vx;
        cmd.sum_vy          <= c.sum_vy;
        cmd.sum_omega       <= c.sum_omega;
        cmd.weight_sum      <= c.weight_sum;
        cmd.current_heading <= c.heading;
        cmd.global_frame    <= c.global_frame;
        do @(posedge i_clk); while (!cmd.ready);
        expected_words.push_back(command_result(c));
    endtask

    task automatic pause_sender();
        cmd.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic write_limit(vccr_pkg::t_cfg_idx idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        unique case (idx)
            vccr_pkg::CFG_MIN_FWD:  lim_min_fwd = longint'(signed'(value));
            vccr_pkg::CFG_MAX_FWD:  lim_max_fwd = longint'(signed'(value));
            vccr_pkg::CFG_MAX_LAT:  lim_max_lat = longint'(value[30:0]);
            vccr_pkg::CFG_MAX_TURN: lim_max_turn = longint'(value[30:0]);
            vccr_pkg::CFG_DT:       lim_dt = longint'(value[16:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 300000) - 150000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd random_command();
        t_cmd c;
        c.sum_vx = rand_word();
        c.sum_vy = rand_word();
        c.sum_omega = rand_word();
        case ($urandom_range(0, 5))
            0: c.weight_sum = -$urandom_range(0, 1000000);
            1: c.weight_sum = $urandom;
            2: c.weight_sum = 1;
            default: c.weight_sum = $urandom_range(1, 400000);
        endcase
        c.heading = 19'($urandom);
        c.global_frame = 1'($urandom);
        return c;
    endfunction

    function automatic t_cmd make_cmd(logic [31:0] a, logic [31:0] b, logic [31:0] w,
                                      logic [31:0] ws, logic [18:0] h, logic g);
        t_cmd c;
        c.sum_vx = a; c.sum_vy = b; c.sum_omega = w;
        c.weight_sum = ws; c.heading = h; c.global_frame = g;
        return c;
    endfunction

    task automatic test_directed();
        send_command(make_cmd(65536, 32768, 65536, 65536, 0, 1'b0));
        send_command(make_cmd(65536, 32768, 65536, 65536, 0, 1'b1));
        // nonpositive weight
        send_command(make_cmd(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1000, 1'b1));
        send_command(make_cmd(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 0, 1'b0));
        // division saturation both ways
        send_command(make_cmd(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0, 1'b0));
        send_command(make_cmd(32'h80000000, 32'h7fffffff, 32'h80000000, 1, 0, 1'b1));
        // heading extremes and wrap both sides
        send_command(make_cmd(65536, 65536, 32'h7fffffff, 65536, 205887, 1'b1));
        send_command(make_cmd(65536, 65536, 32'h80000000, 65536, -205887, 1'b1));
        send_command(make_cmd(65536, -65536, 65536, 65536, 19'h3ffff, 1'b1));
        send_command(make_cmd(65536, -65536, 65536, 65536, 19'h40000, 1'b1));
        send_command(make_cmd(-65536, 65536, 0, 65536, 102944, 1'b1));
        send_command(make_cmd(-65536, 65536, 0, 65536, -102944, 1'b1));
        send_command(make_cmd(-65536, 65536, 0, 32'h7fffffff, 1, 1'b1));
        drain();
    endtask

    task automatic test_limit_settings();
        // wide limits and max time step: large turn step past one wrap
        write_limit(vccr_pkg::CFG_MIN_FWD, 32'h80000000);
        write_limit(vccr_pkg::CFG_MAX_FWD, 32'h7fffffff);
        write_limit(vccr_pkg::CFG_MAX_LAT, 32'h7fffffff);
        write_limit(vccr_pkg::CFG_MAX_TURN, 32'h7fffffff);
        write_limit(vccr_pkg::CFG_DT, 32'h0001ffff);
        send_command(make_cmd(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 205887, 1'b1));
        send_command(make_cmd(32'h80000000, 32'h7fffffff, 32'h80000000, 1, -205887, 1'b1));
        send_command(make_cmd(32'h80000000, 32'h80000000, 32'h40000000, 3, 51472, 1'b1));
        drain();
        // crossed forward limits, zero lateral and turn
        write_limit(vccr_pkg::CFG_MIN_FWD, 32'd200000);
        write_limit(vccr_pkg::CFG_MAX_FWD, -32'sd100000);
        write_limit(vccr_pkg::CFG_MAX_LAT, 32'h0);
        write_limit(vccr_pkg::CFG_MAX_TURN, 32'h0);
        write_limit(vccr_pkg::CFG_DT, 32'h0);
        send_command(make_cmd(32'h7fffffff, 1000, 1000, 65536, 1234, 1'b1));
        send_command(make_cmd(32'h80000000, 1000, 1000, 65536, 1234, 1'b0));
        drain();
    endtask

    task automatic random_phase(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && sent < count) begin
                send_command(random_command());
                sent++;
                burst--;
            end
            if ($urandom_range(0, 2) != 0) pause_sender();
        end
        drain();
    endtask

    task automatic test_random_configs();
        write_limit(vccr_pkg::CFG_MIN_FWD, -32'sd131072);
        write_limit(vccr_pkg::CFG_MAX_FWD, 32'd131072);
        write_limit(vccr_pkg::CFG_MAX_LAT, 32'd98304);
        write_limit(vccr_pkg::CFG_MAX_TURN, 32'd196608);
        write_limit(vccr_pkg::CFG_DT, 32'd6554);
        random_phase(300);
        repeat (3) begin
            write_limit(vccr_pkg::CFG_MIN_FWD, rand_word());
            write_limit(vccr_pkg::CFG_MAX_FWD, rand_word());
            write_limit(vccr_pkg::CFG_MAX_LAT, $urandom);
            write_limit(vccr_pkg::CFG_MAX_TURN, $urandom_range(0, 400000));
            write_limit(vccr_pkg::CFG_DT, $urandom_range(0, 65536));
            random_phase(200);
        end
    endtask

    task automatic test_backpressure();
        // long receiver hold-off while the sender keeps offering words
        hold_off_cycles = 300;
        random_phase(100);
        stall_enable = 1'b0;
        random_phase(60);
        stall_enable = 1'b1;
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        stall_enable = 1'b1;
        lim_min_fwd = 0; lim_max_fwd = 65536; lim_max_lat = 32768;
        lim_max_turn = 65536; lim_dt = 3277;
        i_rst_n <= 1'b0;
        cmd.valid <= 1'b0;
        cmd.sum_vx <= '0; cmd.sum_vy <= '0; cmd.sum_omega <= '0;
        cmd.weight_sum <= '0; cmd.current_heading <= '0; cmd.global_frame <= 1'b0;
        cfg.valid <= 1'b0; cfg.index <= vccr_pkg::CFG_MIN_FWD; cfg.data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limit_settings();
        test_random_configs();
        test_backpressure();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/vccr_pkg.sv
sv/vccr_if.sv
sv/vccr_div.sv
sv/vccr_cordic.sv
sv/velocity_command_clamp_rotate.sv
verif/tb_velocity_command_clamp_rotate.sv
